FILE: design/multi_level_priority_queue_assert.svh
// assertion macros for the priority queue rtl
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define MLPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define MLPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mlpq_pkg.sv
// types, codes and default sizes for the multi-level priority queue
package mlpq_pkg;

	localparam int MAX_LEVELS_DEF  = 8;
	localparam int LEVEL_DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF  = 32;

	localparam int          CFG_W        = 4;
	localparam logic [3:0]  LEVELS_RESET = 4'd8;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int TOTAL_W    = 8;
	localparam int LCOUNT_W   = 5;
	localparam int S_TDATA_W  = 40;
	localparam int M_TDATA_W  = 48;

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_PEEK  = 2'd1,
		OP_DEQ   = 2'd2,
		OP_QUERY = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_FULL  = 2'd1,
		STS_EMPTY = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		UOP_INC,
		UOP_DEC,
		UOP_INC_WRAP
	} uop_t;

	typedef struct packed {
		logic is_zero;
		logic at_lim;
	} uflags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TEST,
		ST_TAIL,
		ST_READ,
		ST_FILL,
		ST_TOTAL,
		ST_FINISH
	} state_t;

endpackage

FILE: design/mlpq_ram.sv
// generic single-port ram with registered read
module mlpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

FILE: design/mlpq_step.sv
// shared increment, decrement and compare unit for pointers and counts
module mlpq_step #(
	parameter int W = 8
) (
	input  mlpq_pkg::uop_t    uop,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      lim,
	output logic [W-1:0]      sum,
	output mlpq_pkg::uflags_t flags
);

	always_comb begin
		flags.is_zero = (a == '0);
		flags.at_lim  = (a == lim);
		case (uop)
			mlpq_pkg::UOP_INC:      sum = a + W'(1);
			mlpq_pkg::UOP_DEC:      sum = a - W'(1);
			mlpq_pkg::UOP_INC_WRAP: sum = flags.at_lim ? '0 : a + W'(1);
			default:                sum = a;
		endcase
	end

endmodule

FILE: design/multi_level_priority_queue.sv
// Multi-level priority queue: one FIFO per priority level, higher level more urgent.
// Input channel s_*: one command per transfer (enqueue, peek, dequeue, query).
// Output channel m_*: exactly one result per command, in command order.
// Config: cfg_we writes cfg_wdata into the active level count (0 acts as 1,
// values above MAX_LEVELS act as MAX_LEVELS); write only while idle.
// One command at a time; a small sequencer drives one shared +/-1 and compare
// unit and a single-port payload ram, one step per cycle unless a finished
// result waits for the output register. Steps from input transfer to result:
//   query or rejected command: straight to the result; enqueue: test for full,
//   and unless full write the tail slot, then update the level fill and total;
//   peek: scan from the top level down to the first non-empty one, then read;
//   dequeue: as peek, then update fill and total; every active level empty: all scanned.
// s_tready is high only while the sequencer waits for a command, so the next
// command can be accepted in the cycle after a result is loaded.
// A finished result sits in the output register until taken; the next command
// is accepted meanwhile, and its result waits if the register is still full.
// Reset clears all counts and pointers and sets 8 active levels; the payload
// ram needs no clearing since only written slots are ever read.
`include "multi_level_priority_queue_assert.svh"

module multi_level_priority_queue #(
	parameter int MAX_LEVELS  = mlpq_pkg::MAX_LEVELS_DEF,
	parameter int LEVEL_DEPTH = mlpq_pkg::LEVEL_DEPTH_DEF,
	parameter int DATA_WIDTH  = mlpq_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// opcode[1:0], priority_req[5:2], data_in[37:6], zero[39:38]
	input  logic [mlpq_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status[1:0], data_out[33:2], total_count[41:34], level_count[46:42], all_empty[47]
	output logic [mlpq_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic                           cfg_we,
	input  logic [mlpq_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int LVL_W     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PTR_W     = $clog2(LEVEL_DEPTH);
	localparam int FILL_W    = $clog2(LEVEL_DEPTH + 1);
	localparam int TOT_W     = $clog2(MAX_LEVELS * LEVEL_DEPTH + 1);
	localparam int U_W       = TOT_W;
	localparam int ACT_W     = 5;
	localparam int RAM_AW    = LVL_W + PTR_W;
	localparam int RAM_DEPTH = 2 ** RAM_AW;

	mlpq_pkg::state_t  state_q, state_d;
	mlpq_pkg::opcode_t op_q;
	mlpq_pkg::status_t status_q;
	logic              prio_ok_q;
	logic [LVL_W-1:0]  lv_q;
	logic [LVL_W-1:0]  cur_q;
	logic [DATA_WIDTH-1:0] din_q;
	logic [mlpq_pkg::CFG_W-1:0] levels_q;

	logic [FILL_W-1:0] fill_q [MAX_LEVELS];
	logic [PTR_W-1:0]  head_q [MAX_LEVELS];
	logic [PTR_W-1:0]  tail_q [MAX_LEVELS];
	logic [TOT_W-1:0]  total_q;

	logic                           out_valid_q;
	logic [mlpq_pkg::M_TDATA_W-1:0] out_q;

	// command decode
	mlpq_pkg::opcode_t s_op;
	logic [3:0]        s_pr;
	logic [ACT_W-1:0]  act;
	logic              s_prio_ok;
	logic              in_xfer;
	logic              finish_go;

	// shared unit and ram hookup
	mlpq_pkg::uop_t    u_op;
	logic [U_W-1:0]    u_a, u_lim, u_sum;
	mlpq_pkg::uflags_t u_flags;
	logic              ram_we, ram_re;
	logic [RAM_AW-1:0] ram_addr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	logic [mlpq_pkg::OUT_DATA_W-1:0] dout;
	logic [mlpq_pkg::LCOUNT_W-1:0]   lcount;

	assign s_op  = mlpq_pkg::opcode_t'(s_tdata[1:0]);
	assign s_pr  = s_tdata[5:2];
	assign in_xfer   = s_tvalid && s_tready;
	assign finish_go = !out_valid_q || m_tready;

	always_comb begin
		if (levels_q == '0) begin
			act = ACT_W'(1);
		end else if (ACT_W'(levels_q) > ACT_W'(MAX_LEVELS)) begin
			act = ACT_W'(MAX_LEVELS);
		end else begin
			act = ACT_W'(levels_q);
		end
		s_prio_ok = (s_pr != '0) && (ACT_W'(s_pr) <= act);
	end

	mlpq_step #(.W(U_W)) u_step (
		.uop   (u_op),
		.a     (u_a),
		.lim   (u_lim),
		.sum   (u_sum),
		.flags (u_flags)
	);

	mlpq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (din_q),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mlpq_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (s_op == mlpq_pkg::OP_PEEK || s_op == mlpq_pkg::OP_DEQ) begin
						state_d = mlpq_pkg::ST_SCAN;
					end else if (s_op == mlpq_pkg::OP_ENQ && s_prio_ok) begin
						state_d = mlpq_pkg::ST_TEST;
					end else begin
						state_d = mlpq_pkg::ST_FINISH;
					end
				end
			end
			mlpq_pkg::ST_SCAN: begin
				if (!u_flags.is_zero) begin
					state_d = mlpq_pkg::ST_READ;
				end else if (cur_q == '0) begin
					state_d = mlpq_pkg::ST_FINISH;
				end
			end
			mlpq_pkg::ST_TEST: begin
				state_d = u_flags.at_lim ? mlpq_pkg::ST_FINISH : mlpq_pkg::ST_TAIL;
			end
			mlpq_pkg::ST_TAIL:  state_d = mlpq_pkg::ST_FILL;
			mlpq_pkg::ST_READ: begin
				state_d = (op_q == mlpq_pkg::OP_DEQ) ? mlpq_pkg::ST_FILL
					: mlpq_pkg::ST_FINISH;
			end
			mlpq_pkg::ST_FILL:  state_d = mlpq_pkg::ST_TOTAL;
			mlpq_pkg::ST_TOTAL: state_d = mlpq_pkg::ST_FINISH;
			mlpq_pkg::ST_FINISH: begin
				if (finish_go) begin
					state_d = mlpq_pkg::ST_IDLE;
				end
			end
			default: state_d = mlpq_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: unit operands and ram controls
	always_comb begin
		s_tready = 1'b0;
		u_op     = (op_q == mlpq_pkg::OP_ENQ) ? mlpq_pkg::UOP_INC : mlpq_pkg::UOP_DEC;
		u_a      = U_W'(fill_q[cur_q]);
		u_lim    = U_W'(LEVEL_DEPTH);
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = {cur_q, head_q[cur_q]};
		unique case (state_q)
			mlpq_pkg::ST_IDLE: s_tready = 1'b1;
			mlpq_pkg::ST_TAIL: begin
				u_op     = mlpq_pkg::UOP_INC_WRAP;
				u_a      = U_W'(tail_q[cur_q]);
				u_lim    = U_W'(LEVEL_DEPTH - 1);
				ram_we   = 1'b1;
				ram_addr = {cur_q, tail_q[cur_q]};
			end
			mlpq_pkg::ST_READ: begin
				u_op   = mlpq_pkg::UOP_INC_WRAP;
				u_a    = U_W'(head_q[cur_q]);
				u_lim  = U_W'(LEVEL_DEPTH - 1);
				ram_re = 1'b1;
			end
			mlpq_pkg::ST_TOTAL: u_a = total_q;
			default: ;
		endcase
	end

	// result fields
	always_comb begin
		if (status_q == mlpq_pkg::STS_OK &&
			(op_q == mlpq_pkg::OP_PEEK || op_q == mlpq_pkg::OP_DEQ)) begin
			dout = mlpq_pkg::OUT_DATA_W'(ram_rdata);
		end else begin
			dout = '0;
		end
		lcount = prio_ok_q ? mlpq_pkg::LCOUNT_W'(fill_q[cur_q]) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mlpq_pkg::ST_IDLE;
			levels_q    <= mlpq_pkg::LEVELS_RESET;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				levels_q <= cfg_wdata;
			end
			// a new result may replace the one taken in the same cycle
			if (state_q == mlpq_pkg::ST_FINISH && finish_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				mlpq_pkg::ST_IDLE: begin
					if (in_xfer) begin
						if (s_op == mlpq_pkg::OP_PEEK || s_op == mlpq_pkg::OP_DEQ) begin
							cur_q <= LVL_W'(act - ACT_W'(1));
						end else begin
							cur_q <= s_prio_ok ? LVL_W'(s_pr - 4'd1) : '0;
						end
					end
				end
				mlpq_pkg::ST_SCAN: begin
					if (u_flags.is_zero) begin
						cur_q <= (cur_q == '0) ? lv_q : cur_q - LVL_W'(1);
					end
				end
				mlpq_pkg::ST_TAIL: tail_q[cur_q] <= PTR_W'(u_sum);
				mlpq_pkg::ST_READ: begin
					if (op_q == mlpq_pkg::OP_DEQ) begin
						head_q[cur_q] <= PTR_W'(u_sum);
					end else begin
						cur_q <= lv_q;
					end
				end
				mlpq_pkg::ST_FILL: fill_q[cur_q] <= FILL_W'(u_sum);
				mlpq_pkg::ST_TOTAL: begin
					total_q <= u_sum;
					cur_q   <= lv_q;
				end
				default: ;
			endcase
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (state_q == mlpq_pkg::ST_IDLE && in_xfer) begin
			op_q      <= s_op;
			prio_ok_q <= s_prio_ok;
			lv_q      <= s_prio_ok ? LVL_W'(s_pr - 4'd1) : '0;
			din_q     <= DATA_WIDTH'(s_tdata[37:6]);
			if ((s_op == mlpq_pkg::OP_ENQ || s_op == mlpq_pkg::OP_QUERY) && !s_prio_ok) begin
				status_q <= mlpq_pkg::STS_RANGE;
			end else begin
				status_q <= mlpq_pkg::STS_OK;
			end
		end
		if (state_q == mlpq_pkg::ST_SCAN && u_flags.is_zero && cur_q == '0) begin
			status_q <= mlpq_pkg::STS_EMPTY;
		end
		if (state_q == mlpq_pkg::ST_TEST && u_flags.at_lim) begin
			status_q <= mlpq_pkg::STS_FULL;
		end
		if (state_q == mlpq_pkg::ST_FINISH && finish_go) begin
			out_q <= {(total_q == '0), lcount, mlpq_pkg::TOTAL_W'(total_q), dout, status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`MLPQ_ASSERT_NEXT(a_one_cmd_in_flight, s_tvalid && s_tready, !s_tready, "command accepted while busy")
	`MLPQ_ASSERT_ALWAYS(a_fill_bound, fill_q[cur_q] <= FILL_W'(LEVEL_DEPTH), "level fill above depth")
	`MLPQ_ASSERT_IMPL(a_scan_active, state_q == mlpq_pkg::ST_SCAN, ACT_W'(cur_q) < act, "scan left the active levels")
	`MLPQ_ASSERT_IMPL(a_err_no_data, m_tvalid && (m_tdata[1:0] != mlpq_pkg::STS_OK), m_tdata[33:2] == '0, "payload on an error result")

endmodule
